/* rtl/cpa_pkg.sv */
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types and constants of the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int unsigned MAX_PAGES_DEF   = 4096;
  localparam int unsigned NUM_REGIONS_DEF = 2;
  localparam int unsigned PAGE_SHIFT_DEF  = 20;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned PAGE_W  = 12;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESERVE  = 3'd0,
    CMD_FREE     = 3'd1,
    CMD_FIND_REG = 3'd2,
    CMD_FIND_ANY = 3'd3,
    CMD_LOCATE   = 3'd4,
    CMD_PAGE_ADR = 3'd5
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT  = 3'd0,
    REG_BASE0  = 3'd1,
    REG_PAGES0 = 3'd2,
    REG_BASE1  = 3'd3,
    REG_PAGES1 = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_TAKE_RD,
    ST_TAKE_WR,
    ST_NEXT_REG,
    ST_DONE
  } state_t;

  // control from sequencer to bitmap memory
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic        wdata;
  } mem_ctl_t;

endpackage

/* rtl/cpa_bitmap.sv */
// ----------------------------------------------------------------------------
// cpa_bitmap
// Reserved-bit memory, one bit per page per region, with a registered read port.
// ----------------------------------------------------------------------------
module cpa_bitmap #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic              clk,
  input  cpa_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     addr,
  output logic              rdata
);
  import cpa_pkg::*;

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= ctl.wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/contiguous_page_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit page allocator over a reserved bitmap for up to two regions.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start / busy         command region first_page page_count align
//                                 reserve address
//  result    done (one cycle)     found result_region page_number
//                                 page_address allocated_count
//  config    cfg_valid/cfg_ready  cfg_index cfg_data
//
// Reset runs a clearing pass over the whole bitmap with busy high. Each page
// a find scans is read from the single bitmap port and then checked; a
// reserve or free writes each page in range, and a found run that is taken
// is then written page by page. The receiver cannot stall.
// ----------------------------------------------------------------------------
module contiguous_page_allocator #(
  parameter int unsigned MAX_PAGES   = cpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned NUM_REGIONS = cpa_pkg::NUM_REGIONS_DEF,
  parameter int unsigned PAGE_SHIFT  = cpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [cpa_pkg::CMD_W-1:0]       command,
  input  logic                            region,
  input  logic [cpa_pkg::PAGE_W-1:0]      first_page,
  input  logic [cpa_pkg::COUNT_W-1:0]     page_count,
  input  logic                            align,
  input  logic                            reserve,
  input  logic [cpa_pkg::ADDR_W-1:0]      address,
  output logic                            done,
  output logic                            found,
  output logic                            result_region,
  output logic [cpa_pkg::PAGE_W-1:0]      page_number,
  output logic [cpa_pkg::ADDR_W-1:0]      page_address,
  output logic [cpa_pkg::CNT_W-1:0]       allocated_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cpa_pkg::*;

  localparam int unsigned PW    = $clog2(MAX_PAGES + 1);   // page counter width
  localparam int unsigned PIW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned DEPTH = NUM_REGIONS * MAX_PAGES;
  localparam int unsigned AW    = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int unsigned XW    = (PW > COUNT_W ? PW : COUNT_W) + 1;

  // config registers
  logic [1:0]         region_count;
  logic [ADDR_W-1:0]  region0_base, region1_base;
  logic [COUNT_W-1:0] region0_pages, region1_pages;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count  <= '0;
      region0_base  <= '0;
      region0_pages <= '0;
      region1_base  <= '0;
      region1_pages <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COUNT:  region_count  <= cfg_data[1:0];
        REG_BASE0:  region0_base  <= cfg_data;
        REG_PAGES0: region0_pages <= cfg_data[COUNT_W-1:0];
        REG_BASE1:  region1_base  <= cfg_data;
        REG_PAGES1: region1_pages <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic usable(input logic r, input logic [1:0] rc);
    logic [1:0] n;
    n = (rc > 2'(NUM_REGIONS)) ? 2'(NUM_REGIONS) : rc;
    return ({1'b0, r} < n) && (32'(r) < NUM_REGIONS);
  endfunction

  function automatic logic [PW-1:0] pages_fn(input logic r, input logic [1:0] rc,
                                             input logic [COUNT_W-1:0] p0,
                                             input logic [COUNT_W-1:0] p1);
    logic [COUNT_W-1:0] p;
    p = r ? p1 : p0;
    if (!usable(r, rc)) return '0;
    if (32'(p) > MAX_PAGES) return PW'(MAX_PAGES);
    return PW'(p);
  endfunction

  // latched command
  cmd_t               cmd;
  logic               reg_sel;
  logic [PAGE_W-1:0]  first;
  logic [COUNT_W-1:0] count;
  logic               al, take;
  logic [ADDR_W-1:0]  addr_in;

  state_t state, state_next;
  logic [AW-1:0]      clr_idx;
  logic [PW-1:0]      idx;       // page under scan / mark
  logic [PW-1:0]      mark_end;
  logic [XW-1:0]      run;
  logic [COUNT_W-1:0] mod;       // idx % count, kept incrementally
  logic               cur;       // region being worked on
  logic [PW-1:0]      fstart;
  logic               fhit;
  logic               mark_set;
  logic [CNT_W-1:0]   cnt0, cnt1;

  logic [PW-1:0] n_cur;
  assign n_cur = pages_fn(cur, region_count, region0_pages, region1_pages);

  mem_ctl_t       mctl;
  logic [AW-1:0]  maddr;
  logic           mrdata;

  cpa_bitmap #(.DEPTH(DEPTH), .AW(AW)) u_bitmap (
    .clk(clk), .ctl(mctl), .addr(maddr), .rdata(mrdata)
  );

  logic [AW-1:0] page_addr;
  assign page_addr = AW'(({{(AW){1'b0}}, cur} * MAX_PAGES) + {{(AW){1'b0}}, idx[PIW-1:0]});

  always_comb begin
    mctl  = '0;
    maddr = page_addr;
    case (state)
      ST_CLEAR: begin
        mctl.wr = 1'b1;
        maddr   = clr_idx;
      end
      ST_FIND_RD: mctl.rd = 1'b1;
      ST_MARK_WR, ST_TAKE_WR: begin
        mctl.wr    = 1'b1;
        mctl.wdata = mark_set;
      end
      default: ;
    endcase
  end

  logic [XW-1:0] run_p1;
  logic          page_free;
  assign run_p1    = run + XW'(1);
  assign page_free = !mrdata && (!al || run != '0 || mod == '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (32'(clr_idx) == DEPTH - 1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          case (command)
            CMD_RESERVE, CMD_FREE: state_next = ST_MARK_RD;
            CMD_FIND_REG, CMD_FIND_ANY: state_next = ST_FIND_RD;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_MARK_RD:  state_next = (idx < mark_end) ? ST_MARK_WR : ST_DONE;
      ST_MARK_WR:  state_next = ST_MARK_RD;
      ST_FIND_RD:  state_next = (count == '0 || idx >= n_cur) ? ST_NEXT_REG : ST_FIND_CHK;
      ST_FIND_CHK: begin
        if (page_free && run_p1 == XW'(count))
          state_next = take ? ST_TAKE_RD : ST_DONE;
        else
          state_next = ST_FIND_RD;
      end
      ST_NEXT_REG: begin
        if (cmd == CMD_FIND_ANY && cur == 1'b0 && NUM_REGIONS > 1) state_next = ST_FIND_RD;
        else state_next = ST_DONE;
      end
      ST_TAKE_RD:  state_next = (idx < mark_end) ? ST_TAKE_WR : ST_DONE;
      ST_TAKE_WR:  state_next = ST_TAKE_RD;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  logic [XW-1:0] end_sum;
  logic [PW-1:0] n_in;
  assign n_in    = pages_fn(region, region_count, region0_pages, region1_pages);
  assign end_sum = XW'(first_page) + XW'(page_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      cnt0    <= '0;
      cnt1    <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: clr_idx <= clr_idx + AW'(1);
        ST_IDLE: begin
          cmd      <= cmd_t'(command);
          reg_sel  <= region;
          first    <= first_page;
          count    <= page_count;
          al       <= align;
          take     <= reserve;
          addr_in  <= address;
          cur      <= (command == CMD_FIND_ANY) ? 1'b0 : region;
          idx      <= (command == CMD_RESERVE || command == CMD_FREE) ?
                      PW'(first_page) : '0;
          mark_end <= (end_sum > XW'(n_in)) ? n_in : PW'(end_sum);
          mark_set <= (command == CMD_RESERVE);
          run      <= '0;
          mod      <= '0;
          fhit     <= 1'b0;
        end
        ST_MARK_WR, ST_TAKE_WR: begin
          idx <= idx + PW'(1);
          if (cur) cnt1 <= mark_set ? cnt1 + 1'b1 : cnt1 - 1'b1;
          else     cnt0 <= mark_set ? cnt0 + 1'b1 : cnt0 - 1'b1;
        end
        ST_FIND_CHK: begin
          run <= page_free ? run_p1 : '0;
          mod <= (mod + COUNT_W'(1) == count) ? '0 : mod + COUNT_W'(1);
          if (page_free && run_p1 == XW'(count)) begin
            fhit     <= 1'b1;
            fstart   <= PW'(XW'(idx) + XW'(1) - XW'(count));
            idx      <= PW'(XW'(idx) + XW'(1) - XW'(count));
            mark_end <= PW'(XW'(idx) + XW'(1));
            mark_set <= 1'b1;
          end else begin
            idx <= idx + PW'(1);
          end
        end
        ST_NEXT_REG: begin
          cur <= 1'b1;
          idx <= '0;
          run <= '0;
          mod <= '0;
        end
        default: ;
      endcase
    end
  end

  // result formation
  logic [63:0] e0, e1;
  logic        in0, in1;
  logic [PW-1:0] np0, np1, npr;
  assign np0 = pages_fn(1'b0, region_count, region0_pages, region1_pages);
  assign np1 = pages_fn(1'b1, region_count, region0_pages, region1_pages);
  assign npr = pages_fn(reg_sel, region_count, region0_pages, region1_pages);
  assign e0  = {32'd0, region0_base} + (64'(np0) << PAGE_SHIFT);
  assign e1  = {32'd0, region1_base} + (64'(np1) << PAGE_SHIFT);
  assign in0 = usable(1'b0, region_count) && addr_in >= region0_base &&
               {32'd0, addr_in} < e0;
  assign in1 = usable(1'b1, region_count) && addr_in >= region1_base &&
               {32'd0, addr_in} < e1;

  logic               r_found, r_reg;
  logic [PAGE_W-1:0]  r_page;
  logic [ADDR_W-1:0]  r_base, r_off;

  always_comb begin
    r_found = 1'b0;
    r_reg   = 1'b0;
    r_page  = '0;
    r_off   = '0;
    case (cmd)
      CMD_RESERVE, CMD_FREE: r_reg = reg_sel;
      CMD_FIND_REG, CMD_FIND_ANY: begin
        r_reg = (cmd == CMD_FIND_REG) ? reg_sel : (fhit & cur);
        if (fhit) begin
          r_found = 1'b1;
          r_page  = PAGE_W'(fstart);
        end
      end
      CMD_LOCATE: begin
        if (in0) begin
          r_found = 1'b1;
          r_off   = addr_in - region0_base;
        end else if (in1) begin
          r_found = 1'b1;
          r_reg   = 1'b1;
          r_off   = addr_in - region1_base;
        end
        r_page = PAGE_W'(r_off >> PAGE_SHIFT);
      end
      CMD_PAGE_ADR: begin
        r_reg = reg_sel;
        if (PW'(first) < npr) begin
          r_found = 1'b1;
          r_page  = first;
        end
      end
      default: ;
    endcase
  end

  assign r_base = r_reg ? region1_base : region0_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
    end
    if (state == ST_DONE) begin
      found           <= r_found;
      result_region   <= r_reg;
      page_number     <= r_page;
      page_address    <= r_found ? r_base + ADDR_W'(64'(r_page) << PAGE_SHIFT) : '0;
      allocated_count <= (32'(r_reg) < NUM_REGIONS) ? (r_reg ? cnt1 : cnt0) : '0;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the contiguous page allocator: commands are driven
// from a queue with random gaps, each accepted item is run through a local
// bitmap allocator model, and every done strobe is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cpa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_BAD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD7 = 3'd7;
  localparam int unsigned NPG   = MAX_PAGES_DEF;
  localparam int unsigned SHIFT = PAGE_SHIFT_DEF;
  localparam longint unsigned CYCLE_LIMIT = 12000000;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic               rgn;
    logic [PAGE_W-1:0]  first;
    logic [COUNT_W-1:0] cnt;
    logic               aln;
    logic               take;
    logic [ADDR_W-1:0]  addr;
  } alloc_cmd_t;

  typedef struct {
    logic              fnd;
    logic              rgn;
    logic [PAGE_W-1:0] pg;
    logic [ADDR_W-1:0] pa;
    logic [CNT_W-1:0]  used;
  } alloc_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] command = '0;
  logic region = 1'b0;
  logic [PAGE_W-1:0] first_page = '0;
  logic [COUNT_W-1:0] page_count = '0;
  logic align = 1'b0;
  logic reserve = 1'b0;
  logic [ADDR_W-1:0] address = '0;
  logic done, found, result_region;
  logic [PAGE_W-1:0] page_number;
  logic [ADDR_W-1:0] page_address;
  logic [CNT_W-1:0] allocated_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  contiguous_page_allocator i_dut (.*);

  always #5 clk = ~clk;

  // local copy of the allocator state
  bit [NPG-1:0]      rsv_map [2];
  logic [CNT_W-1:0]  used_pages [2];
  logic [1:0]        m_rcount;
  logic [ADDR_W-1:0] m_base [2];
  logic [12:0]       m_pages [2];

  alloc_cmd_t cmd_q [$];
  alloc_res_t alloc_results_q [$];
  alloc_cmd_t cur;
  bit  took;
  bit  quiet;
  int  errors;
  int  n_items;
  int  n_results;
  int  n_phases;
  longint unsigned cycles;

  function automatic int unsigned pages_in(logic r);
    int unsigned n;
    int unsigned p;
    n = (m_rcount > 2) ? 2 : m_rcount;
    if (!(r < n)) return 0;
    p = m_pages[r];
    return (p > NPG) ? NPG : p;
  endfunction

  function automatic logic [ADDR_W-1:0] page_addr(logic r, int unsigned pg);
    return m_base[r] + (ADDR_W'(pg) << SHIFT);
  endfunction

  function automatic void mark_pages(logic r, int unsigned first, int unsigned cnt, bit set);
    int unsigned stop;
    stop = first + cnt;
    if (stop > pages_in(r)) stop = pages_in(r);
    for (int unsigned i = first; i < stop; i++) begin
      rsv_map[r][i] = set;
      if (set) used_pages[r]++;
      else used_pages[r]--;
    end
  endfunction

  function automatic bit first_fit(logic r, int unsigned cnt, bit aln, bit take,
                                   output int unsigned st);
    int unsigned n;
    int unsigned run;
    n = pages_in(r);
    run = 0;
    st = 0;
    if (cnt == 0) return 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!rsv_map[r][i] && (!aln || run > 0 || (i % cnt) == 0)) begin
        run++;
        if (run == cnt) begin
          st = i + 1 - cnt;
          if (take) mark_pages(r, st, cnt, 1'b1);
          return 1;
        end
      end else begin
        run = 0;
      end
    end
    return 0;
  endfunction

  function automatic alloc_res_t allocator_step(alloc_cmd_t c);
    alloc_res_t o;
    int unsigned st;
    longint unsigned b, e;
    o = '{default: '0};
    case (c.cmd)
      CMD_RESERVE, CMD_FREE: begin
        o.rgn = c.rgn;
        mark_pages(c.rgn, c.first, c.cnt, c.cmd == CMD_RESERVE);
      end
      CMD_FIND_REG: begin
        o.rgn = c.rgn;
        if (first_fit(c.rgn, c.cnt, c.aln, c.take, st)) begin
          o.fnd = 1'b1;
          o.pg = PAGE_W'(st);
          o.pa = page_addr(c.rgn, st);
        end
      end
      CMD_FIND_ANY: begin
        for (int r = 0; r < 2; r++) begin
          if (first_fit(1'(r), c.cnt, c.aln, c.take, st)) begin
            o.fnd = 1'b1;
            o.rgn = 1'(r);
            o.pg = PAGE_W'(st);
            o.pa = page_addr(1'(r), st);
            break;
          end
        end
      end
      CMD_LOCATE: begin
        for (int r = 0; r < 2; r++) begin
          b = m_base[r];
          e = b + (longint'(pages_in(1'(r))) << SHIFT);
          if (c.addr >= b && c.addr < e) begin
            o.fnd = 1'b1;
            o.rgn = 1'(r);
            o.pg = PAGE_W'((c.addr - b) >> SHIFT);
            o.pa = page_addr(1'(r), o.pg);
            break;
          end
        end
      end
      CMD_PAGE_ADR: begin
        o.rgn = c.rgn;
        if (c.first < pages_in(c.rgn)) begin
          o.fnd = 1'b1;
          o.pg = c.first;
          o.pa = page_addr(c.rgn, c.first);
        end
      end
      default: ;
    endcase
    o.used = used_pages[o.rgn];
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (start && !busy) begin
        alloc_results_q.push_back(allocator_step(cur));
        n_items++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && (!start || took)) begin
      if (cmd_q.size() > 0 && (quiet || $urandom_range(99) >= 28)) begin
        cur = cmd_q.pop_front();
        command <= cur.cmd;
        region <= cur.rgn;
        first_page <= cur.first;
        page_count <= cur.cnt;
        align <= cur.aln;
        reserve <= cur.take;
        address <= cur.addr;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    alloc_res_t x;
    if (!rst && done) begin
      n_results++;
      if (alloc_results_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        x = alloc_results_q.pop_front();
        if (found !== x.fnd) begin
          $error("found exp %0d got %0d", x.fnd, found); errors++;
        end
        if (result_region !== x.rgn) begin
          $error("result_region exp %0d got %0d", x.rgn, result_region); errors++;
        end
        if (page_number !== x.pg) begin
          $error("page_number exp %0d got %0d", x.pg, page_number); errors++;
        end
        if (page_address !== x.pa) begin
          $error("page_address exp %h got %h", x.pa, page_address); errors++;
        end
        if (allocated_count !== x.used) begin
          $error("allocated_count exp %0d got %0d", x.used, allocated_count); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COUNT:  m_rcount = val[1:0];
      REG_BASE0:  m_base[0] = val;
      REG_PAGES0: m_pages[0] = val[12:0];
      REG_BASE1:  m_base[1] = val;
      REG_PAGES1: m_pages[1] = val[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regions(logic [1:0] n, logic [31:0] b0, logic [12:0] p0,
                             logic [31:0] b1, logic [12:0] p1);
    cfg_write(REG_COUNT, n);
    cfg_write(REG_BASE0, b0);
    cfg_write(REG_PAGES0, p0);
    cfg_write(REG_BASE1, b1);
    cfg_write(REG_PAGES1, p1);
    n_phases++;
  endtask

  task automatic push(logic [CMD_W-1:0] c, logic r, int unsigned f, int unsigned n,
                      bit al, bit tk, logic [31:0] a);
    cmd_q.push_back(alloc_cmd_t'{c, r, f[PAGE_W-1:0], n[COUNT_W-1:0], al, tk, a});
  endtask

  task automatic drain();
    while (!(cmd_q.size() == 0 && !start && alloc_results_q.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_random();
    alloc_cmd_t c;
    int unsigned k, lim;
    k = $urandom_range(99);
    c.cmd = (k < 30) ? CMD_RESERVE : (k < 45) ? CMD_FREE : (k < 70) ? CMD_FIND_REG :
            (k < 85) ? CMD_FIND_ANY : (k < 93) ? CMD_LOCATE : (k < 98) ? CMD_PAGE_ADR :
            ($urandom_range(1) ? CMD_BAD6 : CMD_BAD7);
    c.rgn = 1'($urandom_range(1));
    lim = (m_pages[c.rgn] > NPG) ? NPG : m_pages[c.rgn];
    c.first = PAGE_W'(($urandom_range(9) < 8) ? $urandom_range(lim + 1) :
                                                $urandom_range(4095));
    k = $urandom_range(9);
    c.cnt = COUNT_W'((k < 7) ? $urandom_range(8, 1) : (k == 7) ? 0 :
                     (k == 8) ? $urandom_range(8191) : $urandom_range(lim + 1, 1));
    c.aln = 1'($urandom_range(1));
    c.take = 1'($urandom_range(1));
    c.addr = ($urandom_range(9) < 7) ?
             m_base[c.rgn] + $urandom_range((lim + 1) << SHIFT) : $urandom();
    cmd_q.push_back(c);
  endtask

  initial begin
    logic [31:0] b0, b1;
    errors = 0; n_items = 0; n_results = 0; n_phases = 0; cycles = 0; quiet = 0;
    m_rcount = 0; m_base = '{0, 0}; m_pages = '{0, 0};
    used_pages = '{0, 0}; rsv_map[0] = '0; rsv_map[1] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: small regions, region one wraps past the top of memory
    set_regions(2, 32'h0, 16, 32'hFFF0_0000, 8);
    push(CMD_RESERVE, 0, 0, 3, 0, 0, 0);
    push(CMD_RESERVE, 0, 1, 1, 0, 0, 0);
    push(CMD_FREE, 0, 1, 1, 0, 0, 0);
    push(CMD_RESERVE, 0, 14, 5, 0, 0, 0);
    push(CMD_FIND_REG, 0, 0, 0, 0, 0, 0);
    push(CMD_FIND_REG, 0, 0, 4, 1, 0, 0);
    push(CMD_FIND_REG, 0, 0, 2, 0, 1, 0);
    push(CMD_FIND_ANY, 0, 0, 20, 0, 0, 0);
    push(CMD_FIND_ANY, 0, 0, 6, 1, 1, 0);
    push(CMD_FIND_ANY, 1, 0, 8, 0, 1, 0);
    push(CMD_LOCATE, 0, 0, 0, 0, 0, 32'h0);
    push(CMD_LOCATE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    push(CMD_LOCATE, 0, 0, 0, 0, 0, 32'h0100_0000);
    push(CMD_PAGE_ADR, 1, 5, 0, 0, 0, 0);
    push(CMD_PAGE_ADR, 1, 4095, 0, 0, 0, 0);
    push(CMD_PAGE_ADR, 0, 15, 0, 0, 0, 0);
    push(CMD_BAD6, 1, 4095, 8191, 1, 1, 32'hFFFF_FFFF);
    push(CMD_BAD7, 0, 0, 0, 0, 0, 0);
    push(CMD_FREE, 1, 0, 4096, 0, 0, 0);
    push(CMD_FREE, 1, 0, 4096, 0, 0, 0);
    push(CMD_RESERVE, 1, 4095, 8191, 0, 0, 0);
    drain();

    // oversized region zero, count above two, unaligned base
    set_regions(3, 32'hFFFF_FFFF, 8191, 32'h8000_0000, 4096);
    push(CMD_RESERVE, 0, 4090, 4096, 0, 0, 0);
    push(CMD_FIND_REG, 0, 0, 4096, 0, 0, 0);
    push(CMD_FIND_ANY, 0, 0, 4096, 0, 1, 0);
    push(CMD_FIND_REG, 1, 0, 2048, 1, 0, 0);
    push(CMD_LOCATE, 0, 0, 0, 0, 0, 32'hFFFF_FFFE);
    push(CMD_PAGE_ADR, 0, 4095, 0, 0, 0, 0);
    drain();

    // no regions, then only region zero
    set_regions(0, 32'h0010_0000, 4, 32'h0, 4);
    push(CMD_RESERVE, 0, 0, 2, 0, 0, 0);
    push(CMD_FIND_ANY, 0, 0, 1, 0, 1, 0);
    push(CMD_LOCATE, 0, 0, 0, 0, 0, 32'h0010_0000);
    drain();
    set_regions(1, 32'h0, 4, 32'h0, 4);
    push(CMD_FIND_REG, 1, 0, 1, 0, 1, 0);
    push(CMD_PAGE_ADR, 1, 0, 0, 0, 0, 0);
    push(CMD_FIND_ANY, 0, 0, 1, 0, 1, 0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      quiet = (ph == 3);
      b0 = $urandom() & 32'hFFF0_0000;
      b1 = $urandom_range(9) ? ($urandom() & 32'hFFF0_0000) : $urandom();
      set_regions((ph % 3 == 2) ? 2'($urandom_range(3)) : 2'd2, b0,
                  13'($urandom_range(48)), b1, 13'($urandom_range(48, 1)));
      repeat (10) push_random();
      drain();
    end
    quiet = 0;

    $display("%0d commands in %0d region setups, %0d results checked",
             n_items, n_phases, n_results);
    if (errors == 0 && alloc_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
